FILE: hw/rtl/flow_sequence_reorder_tracker_core_assert.svh
// ----------------------------------------------------------------------------
// flow sequence reorder tracker assertion macros
// concurrent checks clocked on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef FLOW_SEQUENCE_REORDER_TRACKER_CORE_ASSERT_SVH
`define FLOW_SEQUENCE_REORDER_TRACKER_CORE_ASSERT_SVH

// same-cycle implication
`define FSRT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/fsrt_pkg.sv
// ----------------------------------------------------------------------------
// fsrt_pkg
// shared sizes, register indexes and request/result types of the tracker
// ----------------------------------------------------------------------------
`default_nettype none

package fsrt_pkg;

  localparam int FLOW_DEPTH  = 1024;
  localparam int IDX_W       = (FLOW_DEPTH > 1) ? $clog2(FLOW_DEPTH) : 1;
  localparam int CNT_W       = $clog2(FLOW_DEPTH + 1);
  localparam int KEY_W       = 48;
  localparam int DATA_W      = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [0:0] CFG_DROP_PERCENT  = 1'b0;
  localparam logic [0:0] CFG_STALE_SECONDS = 1'b1;

  localparam logic [6:0]  DROP_PERCENT_RESET  = 7'd0;
  localparam logic [15:0] STALE_SECONDS_RESET = 16'd120;

  localparam logic signed [31:0] SEQ_FORGOTTEN = -32'sd1;

  typedef struct packed {
    logic [31:0]        src_addr;
    logic [15:0]        src_port;
    logic signed [31:0] seq_num;
    logic [31:0]        now_sec;
    logic               dropped;
  } req_t;

  typedef struct packed {
    logic               dropped;
    logic               new_flow;
    logic               table_full;
    logic               out_of_order;
    logic signed [31:0] stored_high_seq;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fsrt_ram.sv
// ----------------------------------------------------------------------------
// fsrt_ram
// generic single-port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fsrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fsrt_front.sv
// ----------------------------------------------------------------------------
// fsrt_front
// accepts requests, applies the drop rule and hands them to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module fsrt_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        src_addr,
  input  logic [15:0]        src_port,
  input  logic signed [31:0] seq_num,
  input  logic [31:0]        now_sec,
  input  logic [6:0]         random_draw,
  input  logic [6:0]         drop_percent,
  input  logic               q_full,
  output logic               push,
  output fsrt_pkg::req_t     push_req
);

  import fsrt_pkg::*;

  logic held;
  logic accept;
  logic drop_hit;
  req_t hold_req;

  assign drop_hit = (drop_percent != 7'd0) && (random_draw <= drop_percent);
  assign push     = held & ~q_full;
  assign in_stall = held & q_full;
  assign accept   = in_valid & ~in_stall;
  assign push_req = hold_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= accept | (held & q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_req.src_addr <= src_addr;
      hold_req.src_port <= src_port;
      hold_req.seq_num  <= seq_num;
      hold_req.now_sec  <= now_sec;
      hold_req.dropped  <= drop_hit;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fsrt_queue.sv
// ----------------------------------------------------------------------------
// fsrt_queue
// short request queue between the front and the table scan
// ----------------------------------------------------------------------------
`default_nettype none

module fsrt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fsrt_pkg::req_t push_req,
  output logic           full,
  input  logic           pop,
  output fsrt_pkg::req_t pop_req,
  output logic           empty
);

  import fsrt_pkg::*;

  req_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign pop_req = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fsrt_back.sv
// ----------------------------------------------------------------------------
// fsrt_back
// looks up each request that is not dropped in the flow table, updates it and registers the result
// ----------------------------------------------------------------------------
`default_nettype none

`include "flow_sequence_reorder_tracker_core_assert.svh"

module fsrt_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    stale_seconds,
  input  logic           q_empty,
  input  fsrt_pkg::req_t q_req,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output fsrt_pkg::res_t out_res
);

  import fsrt_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_HIT  = 5'b00100,
    ST_EVAL = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t             state, state_next;
  req_t               req;
  res_t               result, result_next;
  logic [CNT_W-1:0]   flow_count, flow_count_next;
  logic [IDX_W-1:0]   scan_idx, scan_idx_next;
  logic signed [31:0] hit_high;
  logic [31:0]        hit_last;
  logic               stale;

  logic [IDX_W-1:0]   ram_addr;
  logic               key_we;
  logic               data_we;
  logic [KEY_W-1:0]   key_wdata;
  logic [DATA_W-1:0]  data_wdata;
  logic [KEY_W-1:0]   key_rdata;
  logic [DATA_W-1:0]  data_rdata;

  req_t               ins_req;
  logic               key_match;
  logic               scan_last;
  logic               room;
  logic signed [31:0] high_eff;
  logic               seq_low;
  logic               out_load;
  logic [3:0]         res_flags;

  fsrt_ram #(.WIDTH(KEY_W), .DEPTH(FLOW_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .addr  (ram_addr),
    .wdata (key_wdata),
    .rdata (key_rdata)
  );

  fsrt_ram #(.WIDTH(DATA_W), .DEPTH(FLOW_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .addr  (ram_addr),
    .wdata (data_wdata),
    .rdata (data_rdata)
  );

  assign ins_req   = (state == ST_IDLE) ? q_req : req;
  assign key_match = (key_rdata == {req.src_addr, req.src_port});
  assign scan_last = ((CNT_W'(scan_idx) + CNT_W'(1)) == flow_count);
  assign room      = (flow_count < CNT_W'(FLOW_DEPTH));
  assign high_eff  = stale ? SEQ_FORGOTTEN : hit_high;
  assign seq_low   = (req.seq_num < high_eff);
  assign out_load  = (state == ST_DONE) && (~out_valid || ~out_stall);

  always_comb begin
    state_next      = state;
    result_next     = result;
    flow_count_next = flow_count;
    scan_idx_next   = scan_idx;
    pop             = 1'b0;
    ram_addr        = '0;
    key_we          = 1'b0;
    data_we         = 1'b0;
    key_wdata       = {ins_req.src_addr, ins_req.src_port};
    data_wdata      = {ins_req.seq_num, ins_req.now_sec};
    unique case (state)
      ST_IDLE: begin
        if (~q_empty) begin
          pop         = 1'b1;
          result_next = '0;
          scan_idx_next = '0;
          if (q_req.dropped) begin
            result_next.dropped = 1'b1;
            state_next          = ST_DONE;
          end else if (flow_count == '0) begin
            // empty table: insert at the first entry
            key_we                      = 1'b1;
            data_we                     = 1'b1;
            flow_count_next             = flow_count + 1'b1;
            result_next.new_flow        = 1'b1;
            result_next.stored_high_seq = q_req.seq_num;
            state_next                  = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (key_match) begin
          state_next = ST_HIT;
        end else if (scan_last) begin
          if (room) begin
            ram_addr                    = flow_count[IDX_W-1:0];
            key_we                      = 1'b1;
            data_we                     = 1'b1;
            flow_count_next             = flow_count + 1'b1;
            result_next.new_flow        = 1'b1;
            result_next.stored_high_seq = req.seq_num;
          end else begin
            result_next.table_full = 1'b1;
          end
          state_next = ST_DONE;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
          ram_addr      = scan_idx + 1'b1;
        end
      end
      ST_HIT: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        ram_addr = scan_idx;
        if (seq_low) begin
          data_we                     = stale;
          data_wdata                  = {SEQ_FORGOTTEN, hit_last};
          result_next.out_of_order    = 1'b1;
          result_next.stored_high_seq = high_eff;
        end else begin
          data_we                     = 1'b1;
          data_wdata                  = {req.seq_num, req.now_sec};
          result_next.stored_high_seq = req.seq_num;
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      flow_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      flow_count <= flow_count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    result   <= result_next;
    scan_idx <= scan_idx_next;
    if (state == ST_IDLE && ~q_empty) begin
      req <= q_req;
    end
    if (state == ST_SCAN && key_match) begin
      hit_high <= data_rdata[DATA_W-1:32];
      hit_last <= data_rdata[31:0];
    end
    if (state == ST_HIT) begin
      stale <= ((req.now_sec - hit_last) >= {16'd0, stale_seconds});
    end
    if (out_load) begin
      out_res <= result;
    end
  end

  assign res_flags = {out_res.dropped, out_res.new_flow, out_res.table_full,
                      out_res.out_of_order};

  `FSRT_ASSERT_IMPL(a_count_bound, 1'b1, flow_count <= CNT_W'(FLOW_DEPTH), "flow count over depth")
  `FSRT_ASSERT_NEXT(a_count_on_insert, !key_we, $stable(flow_count), "count moved without insert")
  `FSRT_ASSERT_IMPL(a_one_flag, out_valid, $onehot0(res_flags), "more than one result flag")
  `FSRT_ASSERT_IMPL(a_pop_idle, pop, state == ST_IDLE && !q_empty, "pop outside idle")

endmodule

`default_nettype wire

FILE: hw/rtl/flow_sequence_reorder_tracker_core.sv
// ----------------------------------------------------------------------------
// flow_sequence_reorder_tracker_core
// per-packet flow tracker: drop rule, flow table lookup, stale and reorder check
//
//   channel  handshake                 payload
//   in       in_valid / in_stall       src_addr src_port seq_num now_sec random_draw
//   out      out_valid / out_stall     dropped new_flow table_full out_of_order
//                                      stored_high_seq
//   cfg      cfg_we                    cfg_index cfg_data
//
// a request passes the front register and the queue; dropped requests and inserts into an
// empty table go straight to the result, others scan the table until a hit or the last entry;
// one table entry is compared per cycle through the single read port of the key memory.
// reset clears flow count and control registers only; table contents need no clearing.
// a two-entry queue and a front register keep accepting while a result is stalled, until full.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_sequence_reorder_tracker_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        src_addr,
  input  logic [15:0]        src_port,
  input  logic signed [31:0] seq_num,
  input  logic [31:0]        now_sec,
  input  logic [6:0]         random_draw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               dropped,
  output logic               new_flow,
  output logic               table_full,
  output logic               out_of_order,
  output logic signed [31:0] stored_high_seq,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  import fsrt_pkg::*;

  logic [6:0]  drop_percent;
  logic [15:0] stale_seconds;
  logic        push;
  req_t        push_req;
  logic        q_full;
  logic        q_empty;
  logic        pop;
  req_t        pop_req;
  res_t        out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_percent  <= DROP_PERCENT_RESET;
      stale_seconds <= STALE_SECONDS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DROP_PERCENT:  drop_percent  <= cfg_data[6:0];
        CFG_STALE_SECONDS: stale_seconds <= cfg_data;
        default:           drop_percent  <= drop_percent;
      endcase
    end
  end

  fsrt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .src_addr     (src_addr),
    .src_port     (src_port),
    .seq_num      (seq_num),
    .now_sec      (now_sec),
    .random_draw  (random_draw),
    .drop_percent (drop_percent),
    .q_full       (q_full),
    .push         (push),
    .push_req     (push_req)
  );

  fsrt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (pop),
    .pop_req  (pop_req),
    .empty    (q_empty)
  );

  fsrt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .stale_seconds (stale_seconds),
    .q_empty       (q_empty),
    .q_req         (pop_req),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res       (out_res)
  );

  assign dropped         = out_res.dropped;
  assign new_flow        = out_res.new_flow;
  assign table_full      = out_res.table_full;
  assign out_of_order    = out_res.out_of_order;
  assign stored_high_seq = out_res.stored_high_seq;

endmodule

`default_nettype wire
